// ===== design/lrc_pkg.sv =====
package lrc_pkg;

  // Operating modes as seen on mode_now.
  localparam logic [2:0] MODE_IDLE      = 3'd0;
  localparam logic [2:0] MODE_CENTRE    = 3'd1;
  localparam logic [2:0] MODE_BLINK     = 3'd2;
  localparam logic [2:0] MODE_SET_BLINK = 3'd3;
  localparam logic [2:0] MODE_SET_HOUR  = 3'd4;
  localparam logic [2:0] MODE_SET_MIN   = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_TICKS_PER_SECOND   = 3'd0;
  localparam logic [2:0] REG_SHOW_PRESS_MIN     = 3'd1;
  localparam logic [2:0] REG_LONG_PRESS_MIN     = 3'd2;
  localparam logic [2:0] REG_SET_PRESS_MIN      = 3'd3;
  localparam logic [2:0] REG_CENTRE_PHASE_TICKS = 3'd4;
  localparam logic [2:0] REG_BLINK_PHASE_TICKS  = 3'd5;
  localparam logic [2:0] REG_BLINK_TOGGLES      = 3'd6;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Toggle count at which set blink ends and set mode shows the hour; the centre LED toggles three times before that.
  localparam logic [3:0] SET_BLINK_TOGGLES = 4'd4;

  typedef struct packed {
    logic [15:0] ticks_per_second;
    logic [15:0] show_press_min;
    logic [15:0] long_press_min;
    logic [15:0] set_press_min;
    logic [15:0] centre_phase_ticks;
    logic [15:0] blink_phase_ticks;
    logic [3:0]  blink_toggles;
  } cfg_t;

  typedef struct packed {
    logic [11:0] ring_leds;
    logic        centre_led;
    logic [3:0]  hour_now;
    logic [5:0]  minute_now;
    logic [5:0]  second_now;
    logic [2:0]  mode_now;
  } result_t;

  // One-hot ring position; positions past eleven light nothing.
  function automatic logic [11:0] ring_bit(input logic [3:0] pos);
    logic [11:0] r;
    r = '0;
    if (pos < 4'd12) begin
      r = 12'(12'd1 << pos);
    end
    return r;
  endfunction

  // Division by five for values up to 63: (x * 13) >> 6 is exact there.
  function automatic logic [3:0] div5(input logic [6:0] x);
    logic [10:0] p;
    p = 11'(x) * 11'd13;
    return p[9:6];
  endfunction

endpackage

// ===== design/led_ring_clock_button_ui.sv =====
// Twelve-LED ring clock with a single button. Every input transaction is one
// tick carrying the button level, and every tick yields exactly one output
// transaction holding the LED drive, the current time and the mode after that
// tick. Ticks are processed at one per clock: the whole tick update (time
// counters, press measurement and the mode sequencer) closes around the state
// registers, so the sustained rate is one transaction per cycle while in_stall
// is low. A two-entry output buffer lets the block keep taking ticks while one
// result waits; in_stall rises only when both entries are full. Configuration
// registers are to be written through cfg_we/cfg_index/cfg_data while the
// block is idle, which the block does not enforce, and reset to the defaults
// (400 ticks per second, show press 400, long press 2000, set press 10, centre
// phase 401, blink phase 301, ten blink toggles). No clearing pass follows
// reset: the block is ready as soon as rst falls.
module led_ring_clock_button_ui (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lrc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               button,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [11:0]                        ring_leds,
  output logic                               centre_led,
  output logic [3:0]                         hour_now,
  output logic [5:0]                         minute_now,
  output logic [5:0]                         second_now,
  output logic [2:0]                         mode_now
);
  import lrc_pkg::*;

  cfg_t    cfg;
  result_t step_result;
  result_t out_data;
  result_t skid_data;
  logic    skid_valid;
  logic    in_take;
  logic    out_take;

  // Configuration registers. Writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_second   <= 16'd400;
      cfg.show_press_min     <= 16'd400;
      cfg.long_press_min     <= 16'd2000;
      cfg.set_press_min      <= 16'd10;
      cfg.centre_phase_ticks <= 16'd401;
      cfg.blink_phase_ticks  <= 16'd301;
      cfg.blink_toggles      <= 4'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICKS_PER_SECOND:   cfg.ticks_per_second   <= cfg_data;
        REG_SHOW_PRESS_MIN:     cfg.show_press_min     <= cfg_data;
        REG_LONG_PRESS_MIN:     cfg.long_press_min     <= cfg_data;
        REG_SET_PRESS_MIN:      cfg.set_press_min      <= cfg_data;
        REG_CENTRE_PHASE_TICKS: cfg.centre_phase_ticks <= cfg_data;
        REG_BLINK_PHASE_TICKS:  cfg.blink_phase_ticks  <= cfg_data;
        REG_BLINK_TOGGLES:      cfg.blink_toggles      <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // A tick is taken whenever the skid entry is free; the state advances in
  // the same edge that the result is captured.
  assign in_stall = skid_valid;
  assign in_take  = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  lrc_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (in_take),
    .button (button),
    .cfg    (cfg),
    .result (step_result)
  );

  // Output register plus skid entry. The skid entry only fills while the
  // output register is held by a stalled transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_take) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_take;
          if (in_take) begin
            out_data <= step_result;
          end
        end
      end else if (in_take) begin
        if (out_valid) begin
          skid_data  <= step_result;
          skid_valid <= 1'b1;
        end else begin
          out_data  <= step_result;
          out_valid <= 1'b1;
        end
      end
    end
  end

  assign ring_leds  = out_data.ring_leds;
  assign centre_led = out_data.centre_led;
  assign hour_now   = out_data.hour_now;
  assign minute_now = out_data.minute_now;
  assign second_now = out_data.second_now;
  assign mode_now   = out_data.mode_now;

`ifndef NO_ASSERTIONS
  // The skid entry is never occupied while the output register is empty.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds data while output register is empty");

  // A tick taken while the output is held must land in the skid entry.
  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    (in_take && out_valid && !out_take) |=> skid_valid)
    else $error("tick taken under stall was not buffered");

  // A buffered result moves forward when the output is taken.
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_take) |=> (out_valid && !skid_valid))
    else $error("skid entry did not drain into the output register");

  // Hours of a twelve-hour clock stay below twelve.
  a_hour_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.hour_now < 4'd12))
    else $error("hour out of range");
`endif

endmodule

// ===== design/lrc_engine.sv =====
module lrc_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             button,
  input  lrc_pkg::cfg_t    cfg,
  output lrc_pkg::result_t result
);
  import lrc_pkg::*;

  logic [15:0] tick_count, tick_count_next;
  logic [5:0]  second_reg, second_reg_next;
  logic [5:0]  minute_reg, minute_reg_next;
  logic [3:0]  hour_reg, hour_reg_next;
  logic [15:0] press_len, press_len_next;
  logic        pressing, pressing_next;
  logic [2:0]  mode_reg, mode_reg_next;
  logic [15:0] phase_count, phase_count_next;
  logic [3:0]  toggle_count, toggle_count_next;
  logic [11:0] ring_reg, ring_reg_next;
  logic        centre_reg, centre_reg_next;
  logic [3:0]  blink_index, blink_index_next;

  logic        measuring;
  logic [15:0] tick_base;
  logic [15:0] tick_inc;
  logic        sec_tick;
  logic [15:0] phase_inc;
  logic [3:0]  blink_pos;

  always_comb begin
    measuring = !(mode_reg == MODE_CENTRE || mode_reg == MODE_BLINK ||
                  mode_reg == MODE_SET_BLINK);

    pressing_next = pressing;
    tick_base     = tick_count;
    if (measuring && button && !pressing) begin
      pressing_next = 1'b1;
      tick_base     = '0;
    end

    // Time of day.
    tick_inc        = tick_base + 16'd1;
    sec_tick        = (tick_inc >= cfg.ticks_per_second);
    tick_count_next = sec_tick ? 16'd0 : tick_inc;
    second_reg_next = second_reg;
    minute_reg_next = minute_reg;
    hour_reg_next   = hour_reg;
    if (sec_tick) begin
      if (second_reg >= 6'd59) begin
        second_reg_next = '0;
        if (minute_reg >= 6'd59) begin
          minute_reg_next = '0;
          hour_reg_next   = (hour_reg >= 4'd11) ? 4'd0 : hour_reg + 4'd1;
        end else begin
          minute_reg_next = minute_reg + 6'd1;
        end
      end else begin
        second_reg_next = second_reg + 6'd1;
      end
    end

    // Press length, saturating.
    press_len_next = press_len;
    if (measuring && button && press_len != 16'hFFFF) begin
      press_len_next = press_len + 16'd1;
    end

    mode_reg_next     = mode_reg;
    phase_count_next  = phase_count;
    toggle_count_next = toggle_count;
    ring_reg_next     = ring_reg;
    centre_reg_next   = centre_reg;
    blink_index_next  = blink_index;
    phase_inc         = phase_count + 16'd1;
    blink_pos         = div5(7'(minute_reg_next) + 7'd2);

    unique case (mode_reg)
      MODE_CENTRE: begin
        phase_count_next = phase_inc;
        if (phase_inc >= cfg.centre_phase_ticks) begin
          centre_reg_next   = 1'b0;
          blink_index_next  = (blink_pos >= 4'd12) ? 4'd0 : blink_pos;
          ring_reg_next     = ring_bit(hour_reg_next) ^ ring_bit(blink_index_next);
          toggle_count_next = 4'd1;
          phase_count_next  = '0;
          mode_reg_next     = MODE_BLINK;
        end
      end
      MODE_BLINK: begin
        phase_count_next = phase_inc;
        if (phase_inc >= cfg.blink_phase_ticks) begin
          phase_count_next = '0;
          if (toggle_count >= cfg.blink_toggles) begin
            ring_reg_next  = '0;
            mode_reg_next  = MODE_IDLE;
            pressing_next  = 1'b0;
            press_len_next = '0;
          end else begin
            ring_reg_next     = ring_reg ^ ring_bit(blink_index);
            toggle_count_next = toggle_count + 4'd1;
          end
        end
      end
      MODE_SET_BLINK: begin
        phase_count_next = phase_inc;
        if (phase_inc >= cfg.centre_phase_ticks) begin
          phase_count_next = '0;
          if (toggle_count >= SET_BLINK_TOGGLES) begin
            mode_reg_next = MODE_SET_HOUR;
            ring_reg_next = ring_bit(hour_reg_next);
          end else begin
            centre_reg_next   = ~centre_reg;
            toggle_count_next = toggle_count + 4'd1;
          end
        end
      end
      MODE_SET_HOUR, MODE_SET_MIN: begin
        if (!button) begin
          if (press_len_next >= cfg.long_press_min) begin
            ring_reg_next = '0;
            if (mode_reg == MODE_SET_HOUR) begin
              mode_reg_next = MODE_SET_MIN;
            end else begin
              mode_reg_next    = MODE_CENTRE;
              centre_reg_next  = 1'b1;
              phase_count_next = '0;
            end
          end else if (press_len_next >= cfg.set_press_min) begin
            ring_reg_next = '0;
            if (mode_reg == MODE_SET_HOUR) begin
              hour_reg_next = (hour_reg_next >= 4'd11) ? 4'd0 : hour_reg_next + 4'd1;
            end else begin
              minute_reg_next = (minute_reg_next >= 6'd51) ? 6'd0 : minute_reg_next + 6'd5;
            end
          end
          press_len_next = '0;
          if (mode_reg_next == MODE_SET_HOUR) begin
            ring_reg_next = ring_reg_next | ring_bit(hour_reg_next);
          end else if (mode_reg_next == MODE_SET_MIN) begin
            ring_reg_next = ring_reg_next | ring_bit(div5(7'(minute_reg_next)));
          end
        end
      end
      default: begin
        mode_reg_next = MODE_IDLE;
        if (!button) begin
          if (press_len_next >= cfg.long_press_min) begin
            mode_reg_next     = MODE_SET_BLINK;
            centre_reg_next   = 1'b1;
            ring_reg_next     = '0;
            phase_count_next  = '0;
            toggle_count_next = 4'd1;
          end else if (press_len_next >= cfg.show_press_min) begin
            mode_reg_next    = MODE_CENTRE;
            centre_reg_next  = 1'b1;
            ring_reg_next    = '0;
            phase_count_next = '0;
          end
          press_len_next = '0;
          pressing_next  = 1'b0;
        end
      end
    endcase

    result.ring_leds  = ring_reg_next;
    result.centre_led = centre_reg_next;
    result.hour_now   = hour_reg_next;
    result.minute_now = minute_reg_next;
    result.second_now = second_reg_next;
    result.mode_now   = mode_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      second_reg   <= '0;
      minute_reg   <= '0;
      hour_reg     <= '0;
      press_len    <= '0;
      pressing     <= 1'b0;
      mode_reg     <= MODE_IDLE;
      phase_count  <= '0;
      toggle_count <= '0;
      ring_reg     <= '0;
      centre_reg   <= 1'b0;
      blink_index  <= '0;
    end else if (step) begin
      tick_count   <= tick_count_next;
      second_reg   <= second_reg_next;
      minute_reg   <= minute_reg_next;
      hour_reg     <= hour_reg_next;
      press_len    <= press_len_next;
      pressing     <= pressing_next;
      mode_reg     <= mode_reg_next;
      phase_count  <= phase_count_next;
      toggle_count <= toggle_count_next;
      ring_reg     <= ring_reg_next;
      centre_reg   <= centre_reg_next;
      blink_index  <= blink_index_next;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lrc_pkg::*;

  // Index that no register answers to; writes there must change nothing.
  localparam logic [2:0] REG_UNUSED = 3'd7;
  // Cycles without any transaction, register write or result before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // Mismatch lines printed before further ones are only counted.
  localparam int REPORT_CAP = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        button = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] ring_leds;
  logic        centre_led;
  logic [3:0]  hour_now;
  logic [5:0]  minute_now;
  logic [5:0]  second_now;
  logic [2:0]  mode_now;

  always #5 clk = ~clk;

  led_ring_clock_button_ui DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .button     (button),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ring_leds  (ring_leds),
    .centre_led (centre_led),
    .hour_now   (hour_now),
    .minute_now (minute_now),
    .second_now (second_now),
    .mode_now   (mode_now)
  );

  // Button levels waiting to be sent, one per tick, and the clock faces
  // (LEDs, time and mode) that the accepted ticks must produce, oldest first.
  logic    button_levels[$];
  result_t due_faces[$];

  // Percent chances that the tick sender idles and that the result side stalls.
  int gap_pct   = 13;
  int stall_pct = 13;

  // Set at each rising edge: whether the tick on the bus was taken there.
  bit tick_taken = 1'b0;

  int ticks_taken   = 0;
  int faces_checked = 0;
  int mismatches    = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;

  // Our own copy of the block: configuration plus every state register,
  // kept at the widths the block uses.
  cfg_t        clock_cfg;
  logic [15:0] tick_cnt;
  logic [5:0]  sec_r;
  logic [5:0]  min_r;
  logic [3:0]  hour_r;
  logic [15:0] press_cnt;
  logic        held;
  logic [2:0]  mode_r;
  logic [15:0] phase_cnt;
  logic [3:0]  toggle_cnt;
  logic [11:0] ring_r;
  logic        centre_r;
  logic [3:0]  blink_pos;

  function automatic logic [11:0] ring_pos(input int p);
    return (p >= 0 && p < 12) ? (12'b1 << p) : 12'b0;
  endfunction

  function automatic void clock_reset();
    clock_cfg.ticks_per_second   = 16'd400;
    clock_cfg.show_press_min     = 16'd400;
    clock_cfg.long_press_min     = 16'd2000;
    clock_cfg.set_press_min      = 16'd10;
    clock_cfg.centre_phase_ticks = 16'd401;
    clock_cfg.blink_phase_ticks  = 16'd301;
    clock_cfg.blink_toggles      = 4'd10;
    tick_cnt   = '0;
    sec_r      = '0;
    min_r      = '0;
    hour_r     = '0;
    press_cnt  = '0;
    held       = 1'b0;
    mode_r     = MODE_IDLE;
    phase_cnt  = '0;
    toggle_cnt = '0;
    ring_r     = '0;
    centre_r   = 1'b0;
    blink_pos  = '0;
  endfunction

  // Advances the predicted clock by one tick and returns the face it shows.
  function automatic result_t step_clock(input logic btn);
    result_t face;
    logic    measuring;
    int      idx;
    int      next_min;
    // Press length is only measured in idle, in the two setting modes and in the unused mode codes.
    measuring = (mode_r == MODE_IDLE) || (mode_r == MODE_SET_HOUR) ||
                (mode_r == MODE_SET_MIN) || (mode_r > MODE_SET_MIN);
    // The first pressed tick restarts the sub-second counter.
    if (measuring && btn && !held) begin
      tick_cnt = '0;
      held = 1'b1;
    end
    // Time runs on every tick, whatever the mode.
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt >= clock_cfg.ticks_per_second) begin
      tick_cnt = '0;
      if (sec_r == 6'd59) begin
        sec_r = '0;
        if (min_r == 6'd59) begin
          min_r = '0;
          hour_r = (hour_r == 4'd11) ? 4'd0 : hour_r + 4'd1;
        end else begin
          min_r = min_r + 6'd1;
        end
      end else begin
        sec_r = sec_r + 6'd1;
      end
    end
    // The press counter sticks at its top value.
    if (measuring && btn && press_cnt != 16'hFFFF) begin
      press_cnt = press_cnt + 16'd1;
    end
    case (mode_r)
      MODE_CENTRE: begin
        phase_cnt = phase_cnt + 16'd1;
        if (phase_cnt >= clock_cfg.centre_phase_ticks) begin
          centre_r = 1'b0;
          ring_r = ring_pos(int'(hour_r));
          // Minute LED is minute/5 rounded; twelve folds back to the top.
          idx = (int'(min_r) + 2) / 5;
          if (idx >= 12) begin
            idx = 0;
          end
          blink_pos = 4'(idx);
          ring_r = ring_r ^ ring_pos(idx);
          toggle_cnt = 4'd1;
          phase_cnt = '0;
          mode_r = MODE_BLINK;
        end
      end
      MODE_BLINK: begin
        phase_cnt = phase_cnt + 16'd1;
        if (phase_cnt >= clock_cfg.blink_phase_ticks) begin
          phase_cnt = '0;
          if (toggle_cnt >= clock_cfg.blink_toggles) begin
            ring_r = '0;
            mode_r = MODE_IDLE;
            held = 1'b0;
            press_cnt = '0;
          end else begin
            ring_r = ring_r ^ ring_pos(int'(blink_pos));
            toggle_cnt = toggle_cnt + 4'd1;
          end
        end
      end
      MODE_SET_BLINK: begin
        phase_cnt = phase_cnt + 16'd1;
        if (phase_cnt >= clock_cfg.centre_phase_ticks) begin
          phase_cnt = '0;
          if (toggle_cnt >= SET_BLINK_TOGGLES) begin
            mode_r = MODE_SET_HOUR;
            ring_r = ring_pos(int'(hour_r));
          end else begin
            centre_r = ~centre_r;
            toggle_cnt = toggle_cnt + 4'd1;
          end
        end
      end
      MODE_SET_HOUR, MODE_SET_MIN: begin
        if (!btn) begin
          if (press_cnt >= clock_cfg.long_press_min) begin
            ring_r = '0;
            if (mode_r == MODE_SET_HOUR) begin
              mode_r = MODE_SET_MIN;
            end else begin
              mode_r = MODE_CENTRE;
              centre_r = 1'b1;
              phase_cnt = '0;
            end
          end else if (press_cnt >= clock_cfg.set_press_min) begin
            ring_r = '0;
            if (mode_r == MODE_SET_HOUR) begin
              hour_r = (hour_r == 4'd11) ? 4'd0 : hour_r + 4'd1;
            end else begin
              next_min = int'(min_r) + 5;
              min_r = (next_min > 55) ? 6'd0 : 6'(next_min);
            end
          end
          press_cnt = '0;
          if (mode_r == MODE_SET_HOUR) begin
            ring_r = ring_r | ring_pos(int'(hour_r));
          end else if (mode_r == MODE_SET_MIN) begin
            ring_r = ring_r | ring_pos(int'(min_r) / 5);
          end
        end
      end
      default: begin
        mode_r = MODE_IDLE;
        if (!btn) begin
          if (press_cnt >= clock_cfg.long_press_min) begin
            mode_r = MODE_SET_BLINK;
            centre_r = 1'b1;
            ring_r = '0;
            phase_cnt = '0;
            toggle_cnt = 4'd1;
          end else if (press_cnt >= clock_cfg.show_press_min) begin
            mode_r = MODE_CENTRE;
            centre_r = 1'b1;
            ring_r = '0;
            phase_cnt = '0;
          end
          press_cnt = '0;
          held = 1'b0;
        end
      end
    endcase
    face.ring_leds  = ring_r;
    face.centre_led = centre_r;
    face.hour_now   = hour_r;
    face.minute_now = min_r;
    face.second_now = sec_r;
    face.mode_now   = mode_r;
    return face;
  endfunction

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
    end
  endtask

  // Rising edge: register writes and accepted ticks update the prediction,
  // and each accepted result is checked against the oldest expected face.
  // Expectations are pushed before the check so that ordering holds even if
  // a result could leave in the same cycle as its tick.
  always @(posedge clk) begin : track_clock
    result_t want;
    bit      busy;
    if (rst) begin
      clock_reset();
      tick_taken = 1'b0;
      quiet_cycles = 0;
    end else begin
      busy = cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          REG_TICKS_PER_SECOND:   clock_cfg.ticks_per_second   = cfg_data;
          REG_SHOW_PRESS_MIN:     clock_cfg.show_press_min     = cfg_data;
          REG_LONG_PRESS_MIN:     clock_cfg.long_press_min     = cfg_data;
          REG_SET_PRESS_MIN:      clock_cfg.set_press_min      = cfg_data;
          REG_CENTRE_PHASE_TICKS: clock_cfg.centre_phase_ticks = cfg_data;
          REG_BLINK_PHASE_TICKS:  clock_cfg.blink_phase_ticks  = cfg_data;
          REG_BLINK_TOGGLES:      clock_cfg.blink_toggles      = cfg_data[3:0];
          default: ;
        endcase
      end
      tick_taken = in_valid && !in_stall;
      if (tick_taken) begin
        due_faces.push_back(step_clock(button));
        ticks_taken++;
        busy = 1'b1;
      end
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (due_faces.size() == 0) begin
          mismatches++;
          $display("%0t: result transaction with none expected, ring %03h mode %0d",
                   $time, ring_leds, mode_now);
        end else begin
          want = due_faces.pop_front();
          faces_checked++;
          compare_field("ring_leds", int'(want.ring_leds), int'(ring_leds));
          compare_field("centre_led", int'(want.centre_led), int'(centre_led));
          compare_field("hour_now", int'(want.hour_now), int'(hour_now));
          compare_field("minute_now", int'(want.minute_now), int'(minute_now));
          compare_field("second_now", int'(want.second_now), int'(second_now));
          compare_field("mode_now", int'(want.mode_now), int'(mode_now));
        end
      end
      // The watchdog only advances while nothing at all moves.
      if (busy) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                   $time, STALL_LIMIT, due_faces.size());
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // Tick sender: a held tick stays on the bus until taken; otherwise the next
  // level is offered unless this cycle is picked as a gap.
  always @(negedge clk) begin : send_ticks
    if (!rst) begin
      if (!in_valid || tick_taken) begin
        if (button_levels.size() > 0 && $urandom_range(99) >= gap_pct) begin
          button   <= button_levels.pop_front();
          in_valid <= 1'b1;
        end else begin
          button   <= 1'($urandom_range(1));
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin : stall_results
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  function automatic int pick(input int lo, input int hi);
    return (hi <= lo) ? lo : int'($urandom_range(hi, lo));
  endfunction

  function automatic void push_level(input logic level, input int n);
    for (int i = 0; i < n; i++) begin
      button_levels.push_back(level);
    end
  endfunction

  // A press of hold ticks followed by rest released ticks.
  function automatic void push_press(input int hold, input int rest);
    push_level(1'b1, hold);
    push_level(1'b0, rest);
  endfunction

  function automatic void push_noise(input int n, input int pct_ones);
    for (int i = 0; i < n; i++) begin
      button_levels.push_back($urandom_range(99) < pct_ones);
    end
  endfunction

  // One user gesture shaped by the current settings. Most are well-formed:
  // a time display, or a whole setting pass with random hour and minute
  // steps. The rest are presses too short to count and plain button noise.
  function automatic void push_gesture();
    int kind;
    int show_min;
    int long_min;
    int step_min;
    int show_len;
    int centre;
    show_min = int'(clock_cfg.show_press_min);
    long_min = int'(clock_cfg.long_press_min);
    step_min = int'(clock_cfg.set_press_min);
    centre   = int'(clock_cfg.centre_phase_ticks);
    show_len = centre + int'(clock_cfg.blink_toggles) *
               int'(clock_cfg.blink_phase_ticks) + 2;
    kind = $urandom_range(99);
    if (kind < 40) begin
      // The display ignores the button, so noise rides along.
      push_press(pick(show_min, long_min - 1), 1);
      push_noise(show_len, 30);
      push_level(1'b0, 2);
    end else if (kind < 65) begin
      push_press(pick(long_min, long_min + 3), 1);
      // Noise stops one tick short of the hour setting so no press starts early.
      push_noise(4 * centre - 1, 30);
      push_level(1'b0, 2);
      repeat ($urandom_range(14)) push_press(pick(step_min, long_min - 1), pick(1, 3));
      if (step_min > 1 && $urandom_range(1)) begin
        push_press(pick(1, step_min - 1), 1);
      end
      push_press(pick(long_min, long_min + 3), 2);
      repeat ($urandom_range(13)) push_press(pick(step_min, long_min - 1), pick(1, 3));
      // Now and then the pass is left open and later gestures land in it.
      if ($urandom_range(3) != 0) begin
        push_press(pick(long_min, long_min + 3), 1);
        push_noise(show_len, 30);
        push_level(1'b0, 2);
      end
    end else if (kind < 80) begin
      push_press(pick(1, show_min - 1), pick(1, 4));
    end else begin
      push_noise(pick(1, 20), 50);
    end
  endfunction

  // Holds until every tick has gone out and every expected face has come back.
  task automatic drain();
    while (button_levels.size() != 0 || due_faces.size() != 0 || in_valid) begin
      @(negedge clk);
    end
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  // Writes every register back to back; the spare index and the unused upper
  // bits of the toggle count get random data, which must be ignored.
  task automatic program_clock(input cfg_t c);
    write_reg(REG_TICKS_PER_SECOND, c.ticks_per_second);
    write_reg(REG_SHOW_PRESS_MIN, c.show_press_min);
    write_reg(REG_LONG_PRESS_MIN, c.long_press_min);
    write_reg(REG_SET_PRESS_MIN, c.set_press_min);
    write_reg(REG_CENTRE_PHASE_TICKS, c.centre_phase_ticks);
    write_reg(REG_BLINK_PHASE_TICKS, c.blink_phase_ticks);
    write_reg(REG_BLINK_TOGGLES, {12'($urandom), c.blink_toggles});
    write_reg(REG_UNUSED, 16'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Walks the clock back to idle using the prediction: long presses close a
  // setting pass, released ticks let a display or the set blink run out.
  task automatic settle_idle();
    push_level(1'b0, 2);
    drain();
    while (mode_r != MODE_IDLE) begin
      if (mode_r == MODE_SET_HOUR || mode_r == MODE_SET_MIN) begin
        push_press(int'(clock_cfg.long_press_min), 1);
      end else begin
        push_level(1'b0, 8);
      end
      drain();
    end
  endtask

  function automatic cfg_t make_cfg(input int tps, input int show_min, input int long_min,
                                    input int step_min, input int centre, input int blink,
                                    input int toggles);
    cfg_t c;
    c.ticks_per_second   = 16'(tps);
    c.show_press_min     = 16'(show_min);
    c.long_press_min     = 16'(long_min);
    c.set_press_min      = 16'(step_min);
    c.centre_phase_ticks = 16'(centre);
    c.blink_phase_ticks  = 16'(blink);
    c.blink_toggles      = 4'(toggles);
    return c;
  endfunction

  initial begin : stimulus
    int show_min;
    int secs;
    int fill;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: a press far below the display threshold does nothing.
    push_press(3, 1);
    drain();

    // Directed walk with tiny settings: a display at 0:00 where the hour and
    // minute LEDs share a position, a press too short to count, then a full
    // setting pass with one hour step and one minute step ending in a display.
    program_clock(make_cfg(3, 2, 4, 1, 1, 1, 2));
    push_press(2, 4);
    push_press(1, 1);
    push_press(4, 5);
    push_press(1, 1);
    push_press(4, 1);
    push_press(1, 1);
    push_press(4, 4);
    drain();

    // Random settings phases. One runs with no idling on either side, one
    // stalls results hard enough to back up into the tick input. Every
    // phase ends with the sender paused until all results are in.
    for (int p = 0; p < 6; p++) begin
      show_min = $urandom_range(8, 2);
      program_clock(make_cfg($urandom_range(20, 1), show_min,
                             show_min + $urandom_range(10, 3),
                             $urandom_range(show_min, 1), $urandom_range(6, 1),
                             $urandom_range(5, 1), $urandom_range(15, 2)));
      gap_pct   = (p == 2) ? 0 : 13;
      stall_pct = (p == 2) ? 0 : ((p == 4) ? 60 : 13);
      while (button_levels.size() < 100) push_gesture();
      drain();
    end
    gap_pct   = 13;
    stall_pct = 13;

    // Lowest legal settings: every press counts as long, every phase lasts a tick.
    program_clock(make_cfg(1, 1, 1, 1, 1, 1, 2));
    while (button_levels.size() < 60) push_gesture();
    drain();

    // Highest settings: no phase can end within a short burst of noise.
    program_clock(make_cfg(65535, 65535, 65535, 65535, 65535, 65535, 15));
    push_noise(60, 50);
    drain();

    // With one tick per second, a setting pass brings the clock to eleven
    // hours and between fifty and fifty-five minutes.
    program_clock(make_cfg(1, 3, 6, 1, 1, 1, 2));
    settle_idle();
    push_press(6, 1);
    push_level(1'b0, 8);
    drain();
    while (mode_r == MODE_SET_HOUR && hour_r != 4'd11) begin
      push_press(1, 1);
      drain();
    end
    push_press(6, 1);
    drain();
    while (mode_r == MODE_SET_MIN && (min_r < 6'd50 || min_r > 6'd55)) begin
      push_press(1, 1);
      drain();
    end
    push_press(6, 1);
    push_level(1'b0, 8);
    drain();
    settle_idle();

    // Minute LED past 57 minutes rounds to twelve and must light the top.
    // The press is timed to start at 58:10.
    secs = int'(min_r) * 60 + int'(sec_r);
    fill = ((58 * 60 + 10 - secs) % 3600 + 3600) % 3600;
    push_level(1'b0, fill);
    push_press(3, 1);
    push_level(1'b0, 8);
    drain();

    // Let the clock run through 11:59:59 so the hour wraps to zero.
    secs = int'(min_r) * 60 + int'(sec_r);
    if (hour_r == 4'd11) begin
      push_level(1'b0, 3600 - secs + 3);
    end
    push_press(3, 1);
    push_level(1'b0, 8);
    drain();

    repeat (10) @(posedge clk);
    if (due_faces.size() != 0) begin
      mismatches += due_faces.size();
      $display("%0t: %0d expected results never arrived", $time, due_faces.size());
    end
    $display("Run covered %0d ticks and %0d checked results under %0d register settings,",
             ticks_taken, faces_checked, settings_used);
    $display("including displays, setting passes, minute LED rounding and the hour wrap.");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
